[design/dq_pkg.sv]
// dq_pkg: shared types, constants and ring helpers for the double-ended queue
// used by dq_ctrl, dq_datapath and the double_ended_queue top level
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } dq_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } dq_state_t;

    typedef enum logic [2:0] {
        ADDR_FRONT,
        ADDR_FRONT_DEC,
        ADDR_BACK,
        ADDR_TAIL,
        ADDR_DUMP
    } dq_addr_sel_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
    } dq_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_out;
        logic [STAT_W-1:0]        status;
        logic                     last;
    } dq_out_t;

    // controller to datapath
    typedef struct packed {
        logic         ram_we;
        logic         ram_re;
        dq_addr_sel_t addr_sel;
        logic         front_dec;
        logic         front_inc;
        logic         count_inc;
        logic         count_dec;
        logic         issued_one;
        logic         issued_inc;
        logic         out_load_const;
        dq_status_t   out_status;
        logic         out_load_rdata;
        logic         out_last;
    } dq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic dump_done;
    } dq_stat_t;

    // (front + off) mod DEPTH, off below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] front,
                                                  input logic [CNT_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = (IDX_W+1)'(front) + (IDX_W+1)'(off);
        if (sum >= (IDX_W+1)'(DEPTH))
            sum = sum - (IDX_W+1)'(DEPTH);
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] front);
        logic [IDX_W-1:0] res;
        if (front == '0)
            res = IDX_W'(DEPTH - 1);
        else
            res = front - IDX_W'(1);
        return res;
    endfunction

endpackage

[design/dq_ram.sv]
// dq_ram: generic single-port RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[design/dq_ctrl.sv]
// dq_ctrl: operation sequencer for the double-ended queue
// depends on dq_pkg; drives dq_datapath through dq_cmd_t
`timescale 1ns / 1ps

module dq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [dq_pkg::OP_W-1:0]   op,
    input  dq_pkg::dq_stat_t          stat,
    output dq_pkg::dq_cmd_t           cmd,
    output logic                      busy
);
    import dq_pkg::*;

    dq_state_t state_reg;
    dq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.addr_sel   = ADDR_FRONT;
        cmd.out_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            cmd.out_load_const = 1'b1;
                            cmd.out_last       = 1'b1;
                            if (stat.full)
                                cmd.out_status = ST_FULL;
                            else
                            begin
                                cmd.ram_we    = 1'b1;
                                cmd.count_inc = 1'b1;
                                if (op == OP_PUSH_FRONT)
                                begin
                                    cmd.addr_sel  = ADDR_FRONT_DEC;
                                    cmd.front_dec = 1'b1;
                                end
                                else
                                    cmd.addr_sel = ADDR_BACK;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load_const = 1'b1;
                                cmd.out_status     = ST_EMPTY;
                                cmd.out_last       = 1'b1;
                            end
                            else
                            begin
                                cmd.ram_re    = 1'b1;
                                cmd.count_dec = 1'b1;
                                if (op == OP_POP_FRONT)
                                begin
                                    cmd.addr_sel  = ADDR_FRONT;
                                    cmd.front_inc = 1'b1;
                                end
                                else
                                    cmd.addr_sel = ADDR_TAIL;
                                state_next = S_POP;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load_const = 1'b1;
                                cmd.out_status     = ST_EMPTY;
                                cmd.out_last       = 1'b1;
                            end
                            else
                            begin
                                cmd.ram_re     = 1'b1;
                                cmd.addr_sel   = ADDR_FRONT;
                                cmd.issued_one = 1'b1;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // unused op codes are dropped without a result
                        end
                    endcase
                end
            end
            S_POP:
            begin
                cmd.out_load_rdata = 1'b1;
                cmd.out_last       = 1'b1;
                state_next         = S_IDLE;
            end
            S_DUMP:
            begin
                // emit the word read last cycle, issue the next read if any remain
                cmd.out_load_rdata = 1'b1;
                cmd.out_last       = stat.dump_done;
                if (stat.dump_done)
                    state_next = S_IDLE;
                else
                begin
                    cmd.ram_re     = 1'b1;
                    cmd.addr_sel   = ADDR_DUMP;
                    cmd.issued_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[design/dq_datapath.sv]
// dq_datapath: ring pointers, entry store and result register
// depends on dq_pkg and dq_ram; commanded by dq_ctrl
`timescale 1ns / 1ps

module dq_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dq_pkg::dq_cmd_t                cmd,
    input  logic signed [dq_pkg::WORD_W-1:0] push_value,
    output dq_pkg::dq_stat_t               stat,
    output logic                           result_valid,
    output dq_pkg::dq_out_t                result
);
    import dq_pkg::*;

    logic [IDX_W-1:0]  front_reg;
    logic [IDX_W-1:0]  front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  issued_reg;
    logic [CNT_W-1:0]  issued_next;
    logic              valid_reg;
    logic              valid_next;
    dq_out_t           out_reg;
    dq_out_t           out_next;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] rdata;

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_FRONT:     addr = front_reg;
            ADDR_FRONT_DEC: addr = ring_dec(front_reg);
            ADDR_BACK:      addr = ring_add(front_reg, count_reg);
            ADDR_TAIL:      addr = ring_add(front_reg, count_reg - CNT_W'(1));
            ADDR_DUMP:      addr = ring_add(front_reg, issued_reg);
            default:        addr = front_reg;
        endcase
    end

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .re    (cmd.ram_re),
        .addr  (addr),
        .wdata (push_value),
        .rdata (rdata)
    );

    always_comb
    begin
        front_next = front_reg;
        if (cmd.front_dec)
            front_next = ring_dec(front_reg);
        else if (cmd.front_inc)
            front_next = ring_add(front_reg, CNT_W'(1));

        count_next = count_reg;
        if (cmd.count_inc)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.count_dec)
            count_next = count_reg - CNT_W'(1);

        issued_next = issued_reg;
        if (cmd.issued_one)
            issued_next = CNT_W'(1);
        else if (cmd.issued_inc)
            issued_next = issued_reg + CNT_W'(1);

        valid_next = cmd.out_load_const | cmd.out_load_rdata;
        out_next   = out_reg;
        if (cmd.out_load_rdata)
        begin
            out_next.value_out = rdata;
            out_next.status    = ST_OK;
            out_next.last      = cmd.out_last;
        end
        else if (cmd.out_load_const)
        begin
            out_next.value_out = '0;
            out_next.status    = cmd.out_status;
            out_next.last      = cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            issued_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            issued_reg <= issued_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.dump_done = (issued_reg == count_reg);

    assign result_valid = valid_reg;
    assign result       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_we |-> !stat.full)
        else $error("store written while full");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_re |-> !stat.empty)
        else $error("store read while empty");

    a_rdata_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load_rdata |-> $past(cmd.ram_re))
        else $error("result taken from a stale read");

endmodule

[design/double_ended_queue.sv]
// double_ended_queue: top level of the bounded double-ended queue
// depends on dq_pkg, dq_ctrl and dq_datapath
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low. Pushes, and pops or
// dumps on an empty queue, give their single result in the cycle after the
// transfer and leave busy low, so one such command fits in every cycle. A pop
// holds busy for one cycle and its result passes through the registered read
// of the entry store and then the result register. A dump holds busy while it
// reads its entries out in order and gives one result per cycle, since the
// store has one read port; last marks the final result. Unused op codes give no
// result. Results are shown for exactly one cycle with result_valid and cannot
// be held off, so the receiver must take them as they come.

module double_ended_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  dq_pkg::dq_in_t  item,
    output logic            busy,
    output logic            result_valid,
    output dq_pkg::dq_out_t result
);
    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (item.op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .push_value   (item.value),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[bench/double_ended_queue_test.sv]
// double_ended_queue_test: self-checking bench for the double_ended_queue top level
// depends on dq_pkg for the transfer structs, op codes and status codes
`timescale 1ns / 1ps

module double_ended_queue_test;

    import dq_pkg::*;

    // op codes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] val;
        int                reps;
        bit                fixed;
        dq_status_t        st;
    } script_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    dq_in_t  item;
    logic    busy;
    logic    result_valid;
    dq_out_t result;

    // driven next to item: typed expectation for directed rows
    bit         row_fixed;
    dq_status_t row_status;

    // shadow of the queue contents
    logic [WORD_W-1:0] shadow_mem [DEPTH];
    int                shadow_head;
    int                shadow_held;

    dq_out_t     predicted [$];
    dq_out_t     pending_results [$];
    script_row_t script [$];

    int err_count;
    int quiet_cycles;
    int idle_pct;
    bit filling;

    int phase_idle  [4] = '{0, 70, 32, 0};
    int phase_items [4] = '{20, 20, 20, 15};

    double_ended_queue u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #1 clk = ~clk;

    task automatic report(input string msg);
        if (err_count < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic dq_out_t mk_result(input logic [WORD_W-1:0] v, input dq_status_t st,
                                          input logic lst);
        dq_out_t r;
        r.value_out = v;
        r.status    = st;
        r.last      = lst;
        return r;
    endfunction

    // computes the results of one accepted command and updates the shadow
    task automatic deque_step(input dq_in_t it);
        int k;
        int pos;
        predicted.delete();
        case (it.op)
            OP_PUSH_FRONT:
                if (shadow_held >= DEPTH)
                    predicted.push_back(mk_result('0, ST_FULL, 1'b1));
                else
                begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_mem[shadow_head] = it.value;
                    shadow_held++;
                    predicted.push_back(mk_result('0, ST_OK, 1'b1));
                end
            OP_PUSH_BACK:
                if (shadow_held >= DEPTH)
                    predicted.push_back(mk_result('0, ST_FULL, 1'b1));
                else
                begin
                    shadow_mem[(shadow_head + shadow_held) % DEPTH] = it.value;
                    shadow_held++;
                    predicted.push_back(mk_result('0, ST_OK, 1'b1));
                end
            OP_POP_FRONT:
                if (shadow_held == 0)
                    predicted.push_back(mk_result('0, ST_EMPTY, 1'b1));
                else
                begin
                    predicted.push_back(mk_result(shadow_mem[shadow_head], ST_OK, 1'b1));
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_held--;
                end
            OP_POP_BACK:
                if (shadow_held == 0)
                    predicted.push_back(mk_result('0, ST_EMPTY, 1'b1));
                else
                begin
                    pos = (shadow_head + shadow_held - 1) % DEPTH;
                    predicted.push_back(mk_result(shadow_mem[pos], ST_OK, 1'b1));
                    shadow_held--;
                end
            OP_DUMP:
                if (shadow_held == 0)
                    predicted.push_back(mk_result('0, ST_EMPTY, 1'b1));
                else
                    for (k = 0; k < shadow_held; k++)
                        predicted.push_back(mk_result(shadow_mem[(shadow_head + k) % DEPTH],
                                                      ST_OK, k == shadow_held - 1));
            default:
                ;
        endcase
    endtask

    task automatic check_result(input dq_out_t got);
        dq_out_t want;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result with nothing pending: value %0d status %0d last %0b",
                             got.value_out, got.status, got.last));
            return;
        end
        want = pending_results.pop_front();
        if (got.value_out !== want.value_out)
            report($sformatf("value_out got %0d expected %0d", got.value_out, want.value_out));
        if (got.status !== want.status)
            report($sformatf("status got %0d expected %0d", got.status, want.status));
        if (got.last !== want.last)
            report($sformatf("last got %0b expected %0b", got.last, want.last));
    endtask

    // results are checked before the new command is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                check_result(result);
            if (start && !busy)
            begin
                deque_step(item);
                if (row_fixed)
                    pending_results.push_back(mk_result('0, row_status, 1'b1));
                else
                    foreach (predicted[k])
                        pending_results.push_back(predicted[k]);
            end
            if (result_valid || (start && !busy))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val,
                        input bit fixed, input dq_status_t st);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        item.op    <= op;
        item.value <= val;
        row_fixed  <= fixed;
        row_status <= st;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every pending result has come out
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 11))
            0:       w = 32'h7fff_ffff;
            1:       w = 32'h8000_0000;
            2:       w = '0;
            3:       w = '1;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // push-heavy while filling, pop-heavy while draining, so the ring sees
    // both the full and the empty end and wraps in between
    function automatic logic [OP_W-1:0] pick_op();
        int r;
        logic [OP_W-1:0] op;
        if (shadow_held >= DEPTH)
            filling = 1'b0;
        else if (shadow_held == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 19) == 0)
            filling = !filling;
        r = $urandom_range(0, 99);
        if (r < 4)
            op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
        else if (r < 12)
            op = OP_DUMP;
        else if ((r < 68) == filling)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        return op;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val,
                                    input int reps, input bit fixed, input dq_status_t st);
        script_row_t row;
        row.op    = op;
        row.val   = val;
        row.reps  = reps;
        row.fixed = fixed;
        row.st    = st;
        script.push_back(row);
    endfunction

    initial
    begin
        int ph;
        int n;
        int k;
        logic [OP_W-1:0] op;

        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        row_fixed    = 1'b0;
        row_status   = ST_OK;
        shadow_head  = 0;
        shadow_held  = 0;
        err_count    = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        filling      = 1'b1;
        foreach (shadow_mem[k])
            shadow_mem[k] = '0;

        // empty queue, extreme words, front index wrapping below zero
        add_row(OP_POP_FRONT,  '0,           1, 1, ST_EMPTY);
        add_row(OP_POP_BACK,   '0,           1, 1, ST_EMPTY);
        add_row(OP_DUMP,       '0,           1, 1, ST_EMPTY);
        add_row(OP_PUSH_BACK,  32'h7fff_ffff, 1, 1, ST_OK);
        add_row(OP_PUSH_FRONT, 32'h8000_0000, 1, 1, ST_OK);
        add_row(OP_PUSH_BACK,  '1,           1, 1, ST_OK);
        add_row(OP_DUMP,       '0,           1, 0, ST_OK);
        add_row(OP_POP_FRONT,  '0,           1, 0, ST_OK);
        add_row(OP_POP_BACK,   '0,           1, 0, ST_OK);
        add_row(OP_POP_BACK,   '0,           1, 0, ST_OK);
        add_row(OP_POP_FRONT,  '0,           1, 1, ST_EMPTY);
        // ignored op codes give nothing
        add_row(OP_SPARE_A,    32'h1234_5678, 1, 0, ST_OK);
        add_row(OP_SPARE_B,    '1,           1, 0, ST_OK);
        add_row(OP_SPARE_C,    '0,           1, 0, ST_OK);
        // fill from both ends, then push into a full queue
        add_row(OP_PUSH_FRONT, 32'h0000_0100, DEPTH / 2, 0, ST_OK);
        add_row(OP_PUSH_BACK,  32'hffff_ff00, DEPTH - DEPTH / 2, 0, ST_OK);
        add_row(OP_PUSH_FRONT, 32'h5555_5555, 1, 1, ST_FULL);
        add_row(OP_PUSH_BACK,  32'haaaa_aaaa, 1, 1, ST_FULL);
        add_row(OP_DUMP,       '0,           1, 0, ST_OK);
        add_row(OP_POP_FRONT,  '0,           1, 0, ST_OK);
        add_row(OP_PUSH_BACK,  '0,           1, 1, ST_OK);
        add_row(OP_DUMP,       '0,           1, 0, ST_OK);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[n])
            for (k = 0; k < script[n].reps; k++)
                send(script[n].op, script[n].val + k, script[n].fixed, script[n].st);
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_idle[ph];
            n = 0;
            while (n < phase_items[ph])
            begin
                op = pick_op();
                send(op, pick_word(), 1'b0, ST_OK);
                if (op <= OP_DUMP)
                    n++;
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
            report($sformatf("%0d results never came", pending_results.size()));

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
design/dq_pkg.sv
design/dq_ram.sv
design/dq_ctrl.sv
design/dq_datapath.sv
design/double_ended_queue.sv
bench/double_ended_queue_test.sv
